// ===== hw/rtl/g2l_pkg.sv =====
package g2l_pkg;

	// Table range: lunar years starting at the 1900 new year
	localparam int unsigned BASE_YEAR  = 1900;
	localparam int unsigned YEAR_COUNT = 150;

	localparam int unsigned LY_W   = 8;   // lunar year index, holds YEAR_COUNT itself
	localparam int unsigned OFS_W  = 17;  // day offset from 1900-01-31
	localparam int unsigned LEN_W  = 9;   // length of a lunar year in days
	localparam int unsigned WORD_W = 17;  // packed table word
	localparam int unsigned SUM_W  = 20;  // day-number arithmetic

	localparam logic [11:0] YEAR_LO = 12'(BASE_YEAR);
	localparam logic [11:0] YEAR_HI = 12'(BASE_YEAR + YEAR_COUNT);

	// Years are counted from 1600, which starts a 400-year cycle
	localparam logic [11:0] EPOCH_YEAR = 12'd1600;
	// Day number of 1900-01-31 counted from 1600-03-01
	localparam logic [SUM_W-1:0] DAY_BASE = SUM_W'(109543);

	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam int unsigned FEST_COUNT = 9;

	typedef struct packed {
		logic [11:0] greg_year;
		logic [3:0]  greg_month;
		logic [4:0]  greg_day;
	} greg_date_t;

	typedef struct packed {
		logic       date_valid;
		logic [3:0] moon_month;
		logic [4:0] moon_day;
		logic       is_leap_month;
		logic [3:0] festival_code;
	} lunar_date_t;

	// Status from the day counter to the sequencer
	typedef struct packed {
		logic             done;
		logic             neg;
		logic [OFS_W-1:0] offset;
	} day_off_t;

	// Bits 16: leap month is long, 15..4: months 1..12 long, 3..0: leap month
	localparam logic [WORD_W-1:0] MOON_ROM [0:YEAR_COUNT-1] = '{
		17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260,
		17'h0d950, 17'h16554, 17'h056a0, 17'h09ad0, 17'h055d2,
		17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255,
		17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977,
		17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40,
		17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970,
		17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
		17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
		17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4,
		17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950, 17'h0b557,
		17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0,
		17'h14573, 17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0,
		17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4, 17'h0a570,
		17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
		17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4,
		17'h0d250, 17'h0d558, 17'h0b540, 17'h0b5a0, 17'h195a6,
		17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a,
		17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570,
		17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50,
		17'h06b58, 17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0,
		17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
		17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5,
		17'h0a950, 17'h0b4a0, 17'h0baa4, 17'h0ad50, 17'h055d9,
		17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
		17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60,
		17'h0a6e6, 17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530,
		17'h05aa0, 17'h076a3, 17'h096d0, 17'h04bd7, 17'h04ad0,
		17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
		17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577,
		17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0
	};

	// Days before each March-based month: (153 * mp + 2) / 5
	localparam logic [8:0] DOY_BASE [0:12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153, 9'd184,
		9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
	};

	localparam logic [3:0] FEST_MONTH [0:FEST_COUNT-1] = '{
		4'd1, 4'd1, 4'd2, 4'd5, 4'd7, 4'd7, 4'd8, 4'd9, 4'd12
	};
	localparam logic [4:0] FEST_DAY [0:FEST_COUNT-1] = '{
		5'd1, 5'd15, 5'd2, 5'd5, 5'd7, 5'd15, 5'd15, 5'd9, 5'd8
	};

	function automatic logic [WORD_W-1:0] rom_word(input logic [LY_W-1:0] idx);
		logic [WORD_W-1:0] w;
		begin
			w = '0;
			if (idx < LY_W'(YEAR_COUNT)) begin
				w = MOON_ROM[idx];
			end
			return w;
		end
	endfunction

	function automatic logic [4:0] leap_len(input logic [WORD_W-1:0] w);
		return (w[3:0] == 4'd0) ? 5'd0 : (w[16] ? 5'd30 : 5'd29);
	endfunction

	function automatic logic [4:0] month_len(input logic [WORD_W-1:0] w, input logic [3:0] m);
		logic [4:0] bit_idx;
		begin
			bit_idx = 5'd16 - 5'(m);
			return w[bit_idx] ? 5'd30 : 5'd29;
		end
	endfunction

	function automatic logic [LEN_W-1:0] year_len(input logic [WORD_W-1:0] w);
		logic [LEN_W-1:0] sum;
		begin
			sum = LEN_W'(348);
			for (int i = 4; i < 16; i++) begin
				sum = sum + LEN_W'(w[i]);
			end
			return sum + LEN_W'(leap_len(w));
		end
	endfunction

	// First festival whose month and day match, 0 for none
	function automatic logic [3:0] fest_code(input logic [3:0] m, input logic [4:0] d);
		logic [3:0] code;
		begin
			code = 4'd0;
			for (int i = FEST_COUNT - 1; i >= 0; i--) begin
				if (FEST_MONTH[i] == m && FEST_DAY[i] == d) begin
					code = 4'(i + 1);
				end
			end
			return code;
		end
	endfunction

endpackage

// ===== hw/rtl/g2l_day_offset.sv =====
module g2l_day_offset (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  g2l_pkg::greg_date_t date,
	output g2l_pkg::day_off_t   res
);

	logic                              month_le2;
	logic [11:0]                       adj_year;
	logic [8:0]                        yoff;
	logic [3:0]                        mp;
	logic [2:0]                        cent;
	logic                              quad_cent;
	logic [11:0]                       corr_c;
	logic [17:0]                       prod_c;
	logic [g2l_pkg::SUM_W-1:0]         sum_c;

	logic                              v_s1;
	logic [17:0]                       prod_s1;
	logic [11:0]                       corr_s1;
	logic                              v_s2;
	logic                              neg_s2;
	logic [g2l_pkg::OFS_W-1:0]         off_s2;

	// Shift January and February to the end of the previous year
	always_comb begin
		month_le2 = date.greg_month <= 4'd2;
		adj_year  = date.greg_year - 12'(month_le2);
		yoff      = 9'(adj_year - g2l_pkg::EPOCH_YEAR);
		mp        = month_le2 ? (date.greg_month + 4'd9) : (date.greg_month - 4'd3);
		priority if (yoff >= 9'd400) cent = 3'd4;
		else if (yoff >= 9'd300)     cent = 3'd3;
		else if (yoff >= 9'd200)     cent = 3'd2;
		else if (yoff >= 9'd100)     cent = 3'd1;
		else                         cent = 3'd0;
		quad_cent = yoff >= 9'd400;
		corr_c = 12'(yoff >> 2) + 12'(quad_cent) - 12'(cent)
			+ 12'(g2l_pkg::DOY_BASE[mp]) + 12'(date.greg_day) - 12'd1;
		prod_c = 18'(yoff) * 18'd365;
	end

	// Sum the day number and take the base date off
	assign sum_c = g2l_pkg::SUM_W'(prod_s1) + {{8{corr_s1[11]}}, corr_s1} - g2l_pkg::DAY_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			prod_s1 <= '0;
			corr_s1 <= '0;
			neg_s2  <= 1'b0;
			off_s2  <= '0;
		end else begin
			v_s1    <= start;
			v_s2    <= v_s1;
			prod_s1 <= prod_c;
			corr_s1 <= corr_c;
			neg_s2  <= sum_c[g2l_pkg::SUM_W-1];
			off_s2  <= sum_c[g2l_pkg::OFS_W-1:0];
		end
	end

	assign res.done   = v_s2;
	assign res.neg    = neg_s2;
	assign res.offset = off_s2;

endmodule

// ===== hw/rtl/gregorian_to_lunar_date.sv =====
// Gregorian to lunar date converter, one date at a time.
// The sequencer waits for the day count, walks whole lunar years (up to 150) and
// then the months, the leap month among them, before it sends the result.
// An out-of-range year skips to the result; a date before the table, once counted.
// A new date is taken only while idle; a stalled result holds the next one.
// Reset clears the sequencer and the result valid; the block comes up idle.
module gregorian_to_lunar_date (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   greg_valid,
	output logic                   greg_stall,
	input  g2l_pkg::greg_date_t    greg,
	output logic                   lunar_valid,
	input  logic                   lunar_stall,
	output g2l_pkg::lunar_date_t   lunar
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CALC  = 5'b00010,
		ST_YEAR  = 5'b00100,
		ST_MONTH = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [g2l_pkg::OFS_W-1:0]       ofs_q;
	logic [g2l_pkg::LY_W-1:0]        ly_q;
	logic [g2l_pkg::WORD_W-1:0]      w_q;
	logic [3:0]                      lm_q;
	logic                            leap_q;
	logic                            ok_q;
	logic                            lunar_valid_q;
	g2l_pkg::lunar_date_t            lunar_q;

	logic                            accept;
	logic                            in_range;
	logic                            out_free;
	logic                            year_end;
	logic [g2l_pkg::WORD_W-1:0]      year_word;
	logic [g2l_pkg::LEN_W-1:0]       len_sel;
	logic [g2l_pkg::OFS_W:0]         diff;
	logic                            borrow;
	logic [4:0]                      day_num;
	g2l_pkg::lunar_date_t            res_c;
	g2l_pkg::day_off_t               off;

	assign greg_stall = state_q != ST_IDLE;
	assign accept     = greg_valid && !greg_stall;
	assign in_range   = greg.greg_year >= g2l_pkg::YEAR_LO && greg.greg_year < g2l_pkg::YEAR_HI;
	assign out_free   = !lunar_valid_q || !lunar_stall;

	g2l_day_offset u_day_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.date   (greg),
		.res    (off)
	);

	// Shared subtractor: take a year or a month off the remaining days
	always_comb begin
		year_word = g2l_pkg::rom_word(ly_q);
		year_end  = ly_q == g2l_pkg::LY_W'(g2l_pkg::YEAR_COUNT);
		if (state_q == ST_MONTH) begin
			len_sel = leap_q ? g2l_pkg::LEN_W'(g2l_pkg::leap_len(w_q))
				: g2l_pkg::LEN_W'(g2l_pkg::month_len(w_q, lm_q));
		end else begin
			len_sel = g2l_pkg::year_len(year_word);
		end
		diff   = {1'b0, ofs_q} - (g2l_pkg::OFS_W + 1)'(len_sel);
		borrow = diff[g2l_pkg::OFS_W];
	end

	// Assemble the result beat
	always_comb begin
		day_num = ofs_q[4:0] + 5'd1;
		res_c   = '0;
		if (ok_q) begin
			res_c.date_valid    = 1'b1;
			res_c.moon_month    = lm_q;
			res_c.moon_day      = day_num;
			res_c.is_leap_month = leap_q;
			res_c.festival_code = leap_q ? 4'd0 : g2l_pkg::fest_code(lm_q, day_num);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ofs_q         <= '0;
			ly_q          <= '0;
			w_q           <= '0;
			lm_q          <= '0;
			leap_q        <= 1'b0;
			ok_q          <= 1'b0;
			lunar_valid_q <= 1'b0;
			lunar_q       <= '0;
		end else begin
			// Load a new result when the register frees up, drop it once taken
			if (state_q == ST_DONE && out_free) begin
				lunar_valid_q <= 1'b1;
			end else if (lunar_valid_q && !lunar_stall) begin
				lunar_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ok_q    <= in_range;
						leap_q  <= 1'b0;
						state_q <= in_range ? ST_CALC : ST_DONE;
					end
				end
				// Wait for the day count
				ST_CALC: begin
					if (off.done) begin
						ofs_q <= off.offset;
						ly_q  <= '0;
						if (off.neg) begin
							ok_q    <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_YEAR;
						end
					end
				end
				// Advance whole lunar years
				ST_YEAR: begin
					if (year_end) begin
						ok_q    <= 1'b0;
						state_q <= ST_DONE;
					end else if (!borrow) begin
						ofs_q <= diff[g2l_pkg::OFS_W-1:0];
						ly_q  <= ly_q + g2l_pkg::LY_W'(1);
					end else begin
						w_q     <= year_word;
						lm_q    <= 4'd1;
						leap_q  <= 1'b0;
						state_q <= ST_MONTH;
					end
				end
				// Advance months, the leap month right after its namesake
				ST_MONTH: begin
					if (lm_q > g2l_pkg::MONTHS_PER_YEAR) begin
						ok_q    <= 1'b0;
						state_q <= ST_DONE;
					end else if (borrow) begin
						state_q <= ST_DONE;
					end else begin
						ofs_q <= diff[g2l_pkg::OFS_W-1:0];
						if (leap_q) begin
							leap_q <= 1'b0;
							lm_q   <= lm_q + 4'd1;
						end else if (w_q[3:0] == lm_q) begin
							leap_q <= 1'b1;
						end else begin
							lm_q <= lm_q + 4'd1;
						end
					end
				end
				// Hold until the output register frees up
				ST_DONE: begin
					if (out_free) begin
						lunar_q <= res_c;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign lunar_valid = lunar_valid_q;
	assign lunar       = lunar_q;

endmodule
